// ===== rtl/core/feal8_pkg.sv =====
// feal8_pkg: shared types and round functions of the FEAL-8 one-way hash pipeline.
// Used by feal8_ks_stage, feal8_enc_stage and feal8_oneway_hash. No dependencies.
package feal8_pkg;

    localparam int ROUNDS = 8;
    localparam logic [7:0] FILL_BYTE = 8'h20;

    // byte j sits at index j
    typedef logic [3:0][7:0]  t_word;
    // subkey bytes K0..K15 as 32 bytes, byte j at index j
    typedef logic [31:0][7:0] t_sub;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word d;
    } t_ks;

    typedef struct packed {
        t_word lft;
        t_word rgt;
    } t_enc;

    function automatic logic [7:0] rot2(input logic [7:0] x, input logic [7:0] y,
                                        input logic c);
        logic [7:0] s;
        s = x + y + {7'd0, c};
        return {s[5:0], s[7:6]};
    endfunction

    function automatic t_word fk_mix(input t_word a, input t_word b);
        logic [7:0] p1;
        logic [7:0] p2;
        t_word      o;
        p1   = a[1] ^ a[0];
        p2   = a[2] ^ a[3];
        p1   = rot2(p1, p2 ^ b[0], 1'b1);
        p2   = rot2(p2, p1 ^ b[1], 1'b0);
        o[0] = rot2(a[0], p1 ^ b[2], 1'b0);
        o[1] = p1;
        o[2] = p2;
        o[3] = rot2(a[3], p2 ^ b[3], 1'b1);
        return o;
    endfunction

    function automatic t_word f_mix(input t_word x, input logic [7:0] k0,
                                    input logic [7:0] k1);
        logic [7:0] p1;
        logic [7:0] p2;
        t_word      o;
        p1   = x[1] ^ x[0] ^ k0;
        p2   = x[2] ^ x[3] ^ k1;
        p1   = rot2(p1, p2, 1'b1);
        p2   = rot2(p2, p1, 1'b0);
        o[0] = rot2(x[0], p1, 1'b0);
        o[1] = p1;
        o[2] = p2;
        o[3] = rot2(x[3], p2, 1'b1);
        return o;
    endfunction

endpackage

// ===== rtl/core/feal8_ks_stage.sv =====
// feal8_ks_stage: one registered fk round of the FEAL key schedule.
// Depends on feal8_pkg.
module feal8_ks_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  feal8_pkg::t_ks   i_ks,
    input  feal8_pkg::t_sub  i_sub,
    output logic             o_valid,
    output feal8_pkg::t_ks   o_ks,
    output feal8_pkg::t_sub  o_sub
);
    import feal8_pkg::*;

    logic  r_valid;
    t_ks   r_ks;
    t_sub  r_sub;
    t_ks   n_ks;
    t_sub  n_sub;
    t_word mixed;

    always_comb begin
        mixed  = fk_mix(i_ks.a, i_ks.b ^ i_ks.d);
        n_ks.d = i_ks.a;
        n_ks.a = i_ks.b;
        n_ks.b = mixed;
        // new subkey word enters at the top; after all rounds round r lands at 4r
        n_sub  = {mixed, i_sub[31:4]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ks  <= n_ks;
        r_sub <= n_sub;
    end

    assign o_valid = r_valid;
    assign o_ks    = r_ks;
    assign o_sub   = r_sub;

endmodule

// ===== rtl/core/feal8_enc_stage.sv =====
// feal8_enc_stage: one registered f round of the FEAL-8 data path.
// Depends on feal8_pkg.
module feal8_enc_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  feal8_pkg::t_enc  i_enc,
    input  logic [7:0]       i_k0,
    input  logic [7:0]       i_k1,
    input  feal8_pkg::t_sub  i_sub,
    output logic             o_valid,
    output feal8_pkg::t_enc  o_enc,
    output feal8_pkg::t_sub  o_sub
);
    import feal8_pkg::*;

    logic  r_valid;
    t_enc  r_enc;
    t_sub  r_sub;
    t_enc  n_enc;
    t_word fo;

    always_comb begin
        fo        = f_mix(i_enc.rgt, i_k0, i_k1);
        n_enc.lft = i_enc.rgt;
        n_enc.rgt = i_enc.lft ^ fo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_enc <= n_enc;
        r_sub <= i_sub;
    end

    assign o_valid = r_valid;
    assign o_enc   = r_enc;
    assign o_sub   = r_sub;

endmodule

// ===== rtl/core/feal8_oneway_hash.sv =====
// feal8_oneway_hash: top level, FEAL-8 encryption of eight 0x20 bytes under a key.
// Depends on feal8_pkg, feal8_ks_stage and feal8_enc_stage.
//
// Usage:
//   Input: drive i_cipher_key and raise start; the key is taken at every rising
//   edge with start high and busy low. busy is always low, so a new key may be
//   given in every cycle.
//   Output: o_valid is high for one cycle with o_hash_value; the receiver takes
//   it in that cycle and cannot hold it off.
//   Pipeline: an accepted key passes through 8 key schedule stages, 8 f-round
//   stages and one output register before the result is taken.
//   Throughput: one key per cycle, set by one fk or f round per pipeline stage.
//   Reset: synchronous, active low; clears all valid bits, dropping any transfer
//   in flight. Payload registers are not reset.
//   Byte 0 of key and result is the most significant byte.
module feal8_oneway_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_cipher_key,
    output logic        o_valid,
    output logic [63:0] o_hash_value
);
    import feal8_pkg::*;

    logic [ROUNDS:0] ks_valid;
    t_ks             ks_bus  [ROUNDS+1];
    t_sub            ks_sub  [ROUNDS+1];
    logic [ROUNDS:0] enc_valid;
    t_enc            enc_bus [ROUNDS+1];
    t_sub            enc_sub [ROUNDS+1];

    logic        r_valid;
    logic [63:0] r_hash;
    t_word       fin_l;
    t_word       fin_r;
    logic [63:0] n_hash;

    assign busy        = 1'b0;
    assign ks_valid[0] = start & ~busy;
    assign ks_sub[0]   = '0;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            ks_bus[0].a[j] = i_cipher_key[63 - 8*j -: 8];
            ks_bus[0].b[j] = i_cipher_key[31 - 8*j -: 8];
            ks_bus[0].d[j] = 8'd0;
        end
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_ks
        feal8_ks_stage u_ks (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ks_valid[g]),
            .i_ks    (ks_bus[g]),
            .i_sub   (ks_sub[g]),
            .o_valid (ks_valid[g+1]),
            .o_ks    (ks_bus[g+1]),
            .o_sub   (ks_sub[g+1])
        );
    end

    // input whitening with K8..K11, then R ^= L
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            enc_bus[0].lft[j] = FILL_BYTE ^ ks_sub[ROUNDS][16 + j];
            enc_bus[0].rgt[j] = ks_sub[ROUNDS][20 + j] ^ ks_sub[ROUNDS][16 + j];
        end
    end
    assign enc_valid[0] = ks_valid[ROUNDS];
    assign enc_sub[0]   = ks_sub[ROUNDS];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_enc
        feal8_enc_stage u_enc (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (enc_valid[g]),
            .i_enc   (enc_bus[g]),
            .i_k0    (enc_sub[g][2*g]),
            .i_k1    (enc_sub[g][2*g + 1]),
            .i_sub   (enc_sub[g]),
            .o_valid (enc_valid[g+1]),
            .o_enc   (enc_bus[g+1]),
            .o_sub   (enc_sub[g+1])
        );
    end

    // final swap (R, L ^ R) and output whitening with K12..K15
    always_comb begin
        fin_l = enc_bus[ROUNDS].rgt;
        fin_r = enc_bus[ROUNDS].lft ^ enc_bus[ROUNDS].rgt;
        for (int j = 0; j < 4; j++) begin
            n_hash[63 - 8*j -: 8] = fin_l[j] ^ enc_sub[ROUNDS][24 + j];
            n_hash[31 - 8*j -: 8] = fin_r[j] ^ enc_sub[ROUNDS][28 + j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= enc_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_valid      = r_valid;
    assign o_hash_value = r_hash;

endmodule

// ===== rtl/core/feal8_chk.sv =====
// feal8_chk: port-level assertions for feal8_oneway_hash, with its bind.
// Depends on feal8_oneway_hash port list only.
module feal8_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] i_cipher_key,
    input logic        o_valid,
    input logic [63:0] o_hash_value
);

    // pipeline never backpressures
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy asserted");

    // every accepted key yields a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##17 o_valid)
        else $error("result missing for accepted key");

    // no result without a matching earlier transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, 17))
        else $error("result without matching input");

    // same key on consecutive transfers gives the same value
    a_pure_function: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid) &&
         ($past(i_cipher_key, 17) == $past(i_cipher_key, 18)))
        |-> (o_hash_value == $past(o_hash_value)))
        else $error("hash differs for equal keys");

endmodule

bind feal8_oneway_hash feal8_chk u_chk (.*);

// ===== test/tb_feal8_oneway_hash.sv =====
// tb_feal8_oneway_hash: self-checking testbench for the FEAL-8 one-way hash block.
// Keys go in through start/busy, and each hash is compared with a local FEAL-8 model.
// Depends on feal8_oneway_hash and its RTL sources only.
`timescale 1ns / 100ps

module tb_feal8_oneway_hash;

    localparam int         NUM_ROUNDS     = 8;
    localparam logic [7:0] PLAIN_BYTE     = 8'h20;
    localparam int         WATCHDOG_LIMIT = 200;
    localparam int         DRAIN_CYCLES   = 24;

    typedef logic [3:0][7:0] quad_t;  // byte j at index j

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_cipher_key;
    logic        o_valid;
    logic [63:0] o_hash_value;

    logic [63:0] hash_q [$];
    logic [63:0] hash_want;
    int          err_count;
    int          keys_sent;
    int          hashes_checked;
    int          quiet_cycles;

    feal8_oneway_hash uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cipher_key (i_cipher_key),
        .o_valid      (o_valid),
        .o_hash_value (o_hash_value)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // 8-bit add with carry-in, wrapped, then rotated left by two
    function automatic logic [7:0] sum_rot2(input logic [7:0] x, input logic [7:0] y,
                                            input logic c);
        logic [7:0] s;
        s = x + y + 8'(c);
        return (s << 2) | (s >> 6);
    endfunction

    // key schedule round
    function automatic quad_t ks_round(input quad_t a, input quad_t b);
        logic [7:0] p;
        logic [7:0] q;
        quad_t      o;
        p    = a[1] ^ a[0];
        q    = a[2] ^ a[3];
        p    = sum_rot2(p, q ^ b[0], 1'b1);
        q    = sum_rot2(q, p ^ b[1], 1'b0);
        o[0] = sum_rot2(a[0], p ^ b[2], 1'b0);
        o[1] = p;
        o[2] = q;
        o[3] = sum_rot2(a[3], q ^ b[3], 1'b1);
        return o;
    endfunction

    // data path round function
    function automatic quad_t data_round(input quad_t x, input logic [7:0] k0,
                                         input logic [7:0] k1);
        logic [7:0] p;
        logic [7:0] q;
        quad_t      o;
        p    = x[1] ^ x[0] ^ k0;
        q    = x[2] ^ x[3] ^ k1;
        p    = sum_rot2(p, q, 1'b1);
        q    = sum_rot2(q, p, 1'b0);
        o[0] = sum_rot2(x[0], p, 1'b0);
        o[1] = p;
        o[2] = q;
        o[3] = sum_rot2(x[3], q, 1'b1);
        return o;
    endfunction

    function automatic logic [63:0] feal8_hash_of(input logic [63:0] key);
        quad_t       a;
        quad_t       b;
        quad_t       d;
        quad_t       mix;
        quad_t       lft;
        quad_t       rgt;
        quad_t       tmp;
        logic [7:0]  sub [32];
        logic [63:0] res;
        for (int j = 0; j < 4; j++) begin
            a[j] = key[63 - 8 * j -: 8];
            b[j] = key[31 - 8 * j -: 8];
        end
        d = '0;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            mix = ks_round(a, b ^ d);
            d   = a;
            a   = b;
            b   = mix;
            for (int j = 0; j < 4; j++)
                sub[4 * r + j] = mix[j];
        end
        for (int j = 0; j < 4; j++) begin
            lft[j] = PLAIN_BYTE ^ sub[16 + j];
            rgt[j] = PLAIN_BYTE ^ sub[20 + j];
        end
        rgt = rgt ^ lft;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            tmp = lft ^ data_round(rgt, sub[2 * r], sub[2 * r + 1]);
            lft = rgt;
            rgt = tmp;
        end
        // final swap: (R, L ^ R)
        tmp = lft ^ rgt;
        lft = rgt;
        rgt = tmp;
        for (int j = 0; j < 4; j++) begin
            res[63 - 8 * j -: 8] = lft[j] ^ sub[24 + j];
            res[31 - 8 * j -: 8] = rgt[j] ^ sub[28 + j];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        case ($urandom_range(3))
            0, 1: k = {$urandom, $urandom};
            2: k = {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
            default: begin
                // one random byte on a flat background
                k = $urandom_range(1) ? '1 : '0;
                k[8 * $urandom_range(7) +: 8] = 8'($urandom);
            end
        endcase
        return k;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ERROR: %s", $time, what);
        err_count++;
    endtask

    task automatic send_key(input logic [63:0] key, input bit allow_idle);
        if (allow_idle) begin
            while ($urandom_range(99) < 17) begin
                @(negedge i_clk);
                start        <= 1'b0;
                i_cipher_key <= {$urandom, $urandom};
            end
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_cipher_key <= key;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // result check and expectation capture, both on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (hash_q.size() == 0) begin
                report_mismatch($sformatf("unexpected hash_value %h", o_hash_value));
            end else begin
                hash_want = hash_q.pop_front();
                if (o_hash_value !== hash_want)
                    report_mismatch($sformatf("hash_value got %h want %h",
                                              o_hash_value, hash_want));
                hashes_checked++;
            end
        end else if (i_rst_n && $isunknown(o_valid)) begin
            report_mismatch("o_valid unknown");
        end
        if (i_rst_n && start && !busy) begin
            hash_q.push_back(feal8_hash_of(i_cipher_key));
            keys_sent++;
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer in %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        logic [63:0] keys [$];
        keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h2020_2020_2020_2020,
                 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                 64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF,
                 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                 64'h7F7F_7F7F_7F7F_7F7F, 64'h8080_8080_8080_8080};
        foreach (keys[i])
            send_key(keys[i], 1'b1);
    endtask

    task automatic test_random_keys(input int count);
        repeat (count)
            send_key(rand_key(), 1'b1);
    endtask

    // full-rate transfer, no gaps
    task automatic test_back_to_back(input int count);
        repeat (count)
            send_key(rand_key(), 1'b0);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cipher_key   = '0;
        err_count      = 0;
        keys_sent      = 0;
        hashes_checked = 0;
        quiet_cycles   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_keys(300);
        test_back_to_back(150);
        test_random_keys(150);

        @(negedge i_clk);
        start <= 1'b0;
        while (hash_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d keys: edge patterns, random, sparse and single-byte keys,",
                 keys_sent);
        $display("with random start gaps and one gapless run; %0d hashes compared.",
                 hashes_checked);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
